@@ sv/clm_pkg.sv @@
// ----------------------------------------------------------------------------
// clm_pkg
// Command and status codes shared by the cursor linked list manager.
// ----------------------------------------------------------------------------
`default_nettype none

package clm_pkg;

    // data width of one list value
    localparam int DW = 32;

    typedef logic [3:0] t_mode;
    typedef logic [1:0] t_status;

    // command codes
    localparam t_mode MODE_CLEAR      = 4'd0;
    localparam t_mode MODE_MOVE_FRONT = 4'd1;
    localparam t_mode MODE_MOVE_BACK  = 4'd2;
    localparam t_mode MODE_MOVE_PREV  = 4'd3;
    localparam t_mode MODE_MOVE_NEXT  = 4'd4;
    localparam t_mode MODE_PREPEND    = 4'd5;
    localparam t_mode MODE_APPEND     = 4'd6;
    localparam t_mode MODE_INS_BEFORE = 4'd7;
    localparam t_mode MODE_INS_AFTER  = 4'd8;
    localparam t_mode MODE_DEL_FRONT  = 4'd9;
    localparam t_mode MODE_DEL_BACK   = 4'd10;
    localparam t_mode MODE_DEL_CURSOR = 4'd11;
    localparam t_mode MODE_QUERY      = 4'd12;

    // status codes
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_NOCUR = 2'd2;
    localparam t_status ST_FULL  = 2'd3;

endpackage

`default_nettype wire

@@ sv/clm_ram.sv @@
// ----------------------------------------------------------------------------
// clm_ram
// Generic single-clock RAM: one bit-masked write port, one read port with
// registered read data that holds while no read is enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module clm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [WIDTH-1:0]         i_wmask,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write the masked bits
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            for (int i = 0; i < WIDTH; i++) begin
                if (i_wmask[i]) begin
                    r_mem[i_waddr][i] <= i_wdata[i];
                end
            end
        end
    end

    // register read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/cursor_linked_list_manager_unit.sv @@
// ----------------------------------------------------------------------------
// cursor_linked_list_manager_unit
// Bounded doubly linked list of 32-bit values with a cursor, kept in a node
// memory with a free chain.
// ----------------------------------------------------------------------------
// Each transaction carries one command and returns one result with status,
// length, cursor index and the front, back and cursor values. Commands are
// taken one at a time. Clear, jump to front or back, query, a step with no
// cursor and refused commands go from acceptance straight to the done state,
// which loads the result register. Step prev/next, prepend, append, the
// inserts and the deletes first pass through the second-read state and the
// two write states. The single node memory sets this: up to two node reads
// on its read port and up to three link updates on its write port, the
// third one in the done state. A stalled result holds the following command
// before its result is loaded. A waiting result does not block acceptance of
// the next command. Nodes that were never handed out are tracked by a fill
// mark, so the block needs no clearing pass after reset.
`default_nettype none

module cursor_linked_list_manager_unit #(
    parameter int CAPACITY = 256
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic [3:0]                            i_mode,
    input  wire logic signed [31:0]                    i_value,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic [1:0]                                 o_status,
    output logic [$clog2(CAPACITY+1)-1:0]              o_list_length,
    output logic signed [$clog2(CAPACITY):0]           o_cursor_position,
    output logic signed [31:0]                         o_front_value,
    output logic signed [31:0]                         o_back_value,
    output logic signed [31:0]                         o_cursor_value
);

    localparam int DW = clm_pkg::DW;
    localparam int PW = $clog2(CAPACITY + 1);   // pointer, null is CAPACITY
    localparam int AW = $clog2(CAPACITY);       // memory address
    localparam int LW = PW;                     // length
    localparam int CW = AW + 1;                 // signed cursor index
    localparam int NW = DW + 2 * PW;

    localparam logic [PW-1:0] NIL = PW'(CAPACITY);
    localparam logic signed [CW-1:0] IDX_NONE = '1;

    typedef struct packed {
        logic signed [DW-1:0] value;
        logic [PW-1:0]        nxt;
        logic [PW-1:0]        prv;
    } t_node;

    localparam t_node M_ALL = '{value: '1, nxt: '1, prv: '1};
    localparam t_node M_NXT = '{value: '0, nxt: '1, prv: '0};
    localparam t_node M_PRV = '{value: '0, nxt: '0, prv: '1};

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD2,
        S_W1,
        S_W2,
        S_DONE
    } t_state;

    function automatic logic [AW-1:0] addr_of(input logic [PW-1:0] p);
        return p[AW-1:0];
    endfunction

    // list state
    t_state                r_state, n_state;
    logic [PW-1:0]         r_head, n_head;
    logic [PW-1:0]         r_tail, n_tail;
    logic [PW-1:0]         r_cur, n_cur;
    logic signed [CW-1:0]  r_cidx, n_cidx;
    logic [PW-1:0]         r_free, n_free;
    logic [PW-1:0]         r_fresh, n_fresh;
    logic [LW-1:0]         r_count, n_count;
    logic signed [DW-1:0]  r_front_val, n_front_val;
    logic signed [DW-1:0]  r_back_val, n_back_val;
    logic signed [DW-1:0]  r_cur_val, n_cur_val;

    // command in flight
    clm_pkg::t_mode        r_mode, n_mode;
    logic signed [DW-1:0]  r_value, n_value;
    clm_pkg::t_status      r_status, n_status;
    logic                  r_mem, n_mem;
    t_node                 r_d1, n_d1;

    // result register
    logic                  r_out_valid, n_out_valid;
    clm_pkg::t_status      r_o_status, n_o_status;
    logic [LW-1:0]         r_o_len, n_o_len;
    logic signed [CW-1:0]  r_o_cidx, n_o_cidx;
    logic signed [DW-1:0]  r_o_front, n_o_front;
    logic signed [DW-1:0]  r_o_back, n_o_back;
    logic signed [DW-1:0]  r_o_cur, n_o_cur;

    // memory port signals
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    t_node                 rd_node;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    t_node                 wr_data;
    t_node                 wr_mask;

    logic                  in_acc;
    logic                  out_take;
    logic                  commit;
    logic                  empty;
    logic                  nocur;
    logic                  full;
    clm_pkg::t_status      acc_status;
    logic                  acc_mem;
    logic                  take_op;
    logic                  take_fresh;
    t_node                 anc;
    logic [LW-1:0]         cnt_m1;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_take   = r_out_valid && !i_out_stall;

    assign empty = (r_head == NIL);
    assign nocur = (r_cur == NIL);
    assign full  = (r_free == NIL);

    assign take_op = (r_mode == clm_pkg::MODE_PREPEND) || (r_mode == clm_pkg::MODE_APPEND)
                  || (r_mode == clm_pkg::MODE_INS_BEFORE)
                  || (r_mode == clm_pkg::MODE_INS_AFTER);
    assign take_fresh = (r_free == r_fresh);
    // the node around which the command works: cursor node for inserts,
    // otherwise the first node read
    assign anc    = take_op ? rd_node : r_d1;
    assign cnt_m1 = r_count - 1'b1;

    // node memory: value and both links of every node
    clm_ram #(
        .WIDTH (NW),
        .DEPTH (CAPACITY)
    ) u_nodes (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_wmask (wr_mask),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_node)
    );

    // check a new command against the current list
    always_comb begin
        acc_status = clm_pkg::ST_OK;
        acc_mem    = 1'b0;
        case (i_mode)
            clm_pkg::MODE_MOVE_PREV, clm_pkg::MODE_MOVE_NEXT: begin
                acc_mem = !nocur;
            end
            clm_pkg::MODE_PREPEND, clm_pkg::MODE_APPEND: begin
                if (full) acc_status = clm_pkg::ST_FULL;
                acc_mem = !full;
            end
            clm_pkg::MODE_INS_BEFORE, clm_pkg::MODE_INS_AFTER: begin
                if (empty)      acc_status = clm_pkg::ST_EMPTY;
                else if (nocur) acc_status = clm_pkg::ST_NOCUR;
                else if (full)  acc_status = clm_pkg::ST_FULL;
                acc_mem = !empty && !nocur && !full;
            end
            clm_pkg::MODE_DEL_FRONT, clm_pkg::MODE_DEL_BACK: begin
                if (empty) acc_status = clm_pkg::ST_EMPTY;
                acc_mem = !empty;
            end
            clm_pkg::MODE_DEL_CURSOR: begin
                if (empty)      acc_status = clm_pkg::ST_EMPTY;
                else if (nocur) acc_status = clm_pkg::ST_NOCUR;
                acc_mem = !empty && !nocur;
            end
            default: begin
                acc_status = clm_pkg::ST_OK;
            end
        endcase
    end

    // issue node reads: first read on acceptance, second one after it
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (r_state == S_IDLE) begin
            rd_en = in_acc && acc_mem;
            case (i_mode)
                clm_pkg::MODE_PREPEND, clm_pkg::MODE_APPEND,
                clm_pkg::MODE_INS_BEFORE, clm_pkg::MODE_INS_AFTER: rd_addr = addr_of(r_free);
                clm_pkg::MODE_DEL_FRONT: rd_addr = addr_of(r_head);
                clm_pkg::MODE_DEL_BACK:  rd_addr = addr_of(r_tail);
                default:                 rd_addr = addr_of(r_cur);
            endcase
        end else if (r_state == S_RD2) begin
            case (r_mode)
                clm_pkg::MODE_INS_BEFORE, clm_pkg::MODE_INS_AFTER: begin
                    rd_en   = 1'b1;
                    rd_addr = addr_of(r_cur);
                end
                clm_pkg::MODE_MOVE_PREV, clm_pkg::MODE_DEL_BACK: begin
                    rd_en   = 1'b1;
                    rd_addr = addr_of(rd_node.prv);
                end
                clm_pkg::MODE_MOVE_NEXT, clm_pkg::MODE_DEL_FRONT: begin
                    rd_en   = 1'b1;
                    rd_addr = addr_of(rd_node.nxt);
                end
                clm_pkg::MODE_DEL_CURSOR: begin
                    rd_en   = 1'b1;
                    rd_addr = (rd_node.prv == NIL) ? addr_of(rd_node.nxt)
                                                   : addr_of(rd_node.prv);
                end
                default: begin
                    rd_en = 1'b0;
                end
            endcase
        end
    end

    // link updates: clear on acceptance, then up to three slots
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        wr_mask = '0;
        if (r_state == S_IDLE) begin
            // hang the whole list in front of the free chain
            wr_en   = in_acc && (i_mode == clm_pkg::MODE_CLEAR) && !empty;
            wr_addr = addr_of(r_tail);
            wr_data = '{value: '0, nxt: r_free, prv: '0};
            wr_mask = M_NXT;
        end else if (r_state == S_W1 || r_state == S_W2
                     || (r_state == S_DONE && r_mem)) begin
            case (r_mode)
                clm_pkg::MODE_PREPEND: begin
                    if (r_state == S_W1) begin
                        wr_en   = 1'b1;
                        wr_addr = addr_of(r_free);
                        wr_data = '{value: r_value, nxt: r_head, prv: NIL};
                        wr_mask = M_ALL;
                    end else if (r_state == S_W2) begin
                        wr_en   = !empty;
                        wr_addr = addr_of(r_head);
                        wr_data = '{value: '0, nxt: '0, prv: r_free};
                        wr_mask = M_PRV;
                    end
                end
                clm_pkg::MODE_APPEND: begin
                    if (r_state == S_W1) begin
                        wr_en   = 1'b1;
                        wr_addr = addr_of(r_free);
                        wr_data = '{value: r_value, nxt: NIL, prv: r_tail};
                        wr_mask = M_ALL;
                    end else if (r_state == S_W2) begin
                        wr_en   = !empty;
                        wr_addr = addr_of(r_tail);
                        wr_data = '{value: '0, nxt: r_free, prv: '0};
                        wr_mask = M_NXT;
                    end
                end
                clm_pkg::MODE_INS_BEFORE: begin
                    if (r_state == S_W1) begin
                        wr_en   = 1'b1;
                        wr_addr = addr_of(r_free);
                        wr_data = '{value: r_value, nxt: r_cur, prv: anc.prv};
                        wr_mask = M_ALL;
                    end else if (r_state == S_W2) begin
                        wr_en   = (anc.prv != NIL);
                        wr_addr = addr_of(anc.prv);
                        wr_data = '{value: '0, nxt: r_free, prv: '0};
                        wr_mask = M_NXT;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = addr_of(r_cur);
                        wr_data = '{value: '0, nxt: '0, prv: r_free};
                        wr_mask = M_PRV;
                    end
                end
                clm_pkg::MODE_INS_AFTER: begin
                    if (r_state == S_W1) begin
                        wr_en   = 1'b1;
                        wr_addr = addr_of(r_free);
                        wr_data = '{value: r_value, nxt: anc.nxt, prv: r_cur};
                        wr_mask = M_ALL;
                    end else if (r_state == S_W2) begin
                        wr_en   = (anc.nxt != NIL);
                        wr_addr = addr_of(anc.nxt);
                        wr_data = '{value: '0, nxt: '0, prv: r_free};
                        wr_mask = M_PRV;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = addr_of(r_cur);
                        wr_data = '{value: '0, nxt: r_free, prv: '0};
                        wr_mask = M_NXT;
                    end
                end
                clm_pkg::MODE_DEL_FRONT: begin
                    if (r_state == S_W1) begin
                        wr_en   = (anc.nxt != NIL);
                        wr_addr = addr_of(anc.nxt);
                        wr_data = '{value: '0, nxt: '0, prv: NIL};
                        wr_mask = M_PRV;
                    end else if (r_state == S_W2) begin
                        wr_en   = 1'b1;
                        wr_addr = addr_of(r_head);
                        wr_data = '{value: '0, nxt: r_free, prv: '0};
                        wr_mask = M_NXT;
                    end
                end
                clm_pkg::MODE_DEL_BACK: begin
                    if (r_state == S_W1) begin
                        wr_en   = (anc.prv != NIL);
                        wr_addr = addr_of(anc.prv);
                        wr_data = '{value: '0, nxt: NIL, prv: '0};
                        wr_mask = M_NXT;
                    end else if (r_state == S_W2) begin
                        wr_en   = 1'b1;
                        wr_addr = addr_of(r_tail);
                        wr_data = '{value: '0, nxt: r_free, prv: '0};
                        wr_mask = M_NXT;
                    end
                end
                clm_pkg::MODE_DEL_CURSOR: begin
                    if (r_state == S_W1) begin
                        wr_en   = (anc.prv != NIL);
                        wr_addr = addr_of(anc.prv);
                        wr_data = '{value: '0, nxt: anc.nxt, prv: '0};
                        wr_mask = M_NXT;
                    end else if (r_state == S_W2) begin
                        wr_en   = (anc.nxt != NIL);
                        wr_addr = addr_of(anc.nxt);
                        wr_data = '{value: '0, nxt: '0, prv: anc.prv};
                        wr_mask = M_PRV;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = addr_of(r_cur);
                        wr_data = '{value: '0, nxt: r_free, prv: '0};
                        wr_mask = M_NXT;
                    end
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    // sequence the command and work out the new list state
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_cur       = r_cur;
        n_cidx      = r_cidx;
        n_free      = r_free;
        n_fresh     = r_fresh;
        n_count     = r_count;
        n_front_val = r_front_val;
        n_back_val  = r_back_val;
        n_cur_val   = r_cur_val;
        n_mode      = r_mode;
        n_value     = r_value;
        n_status    = r_status;
        n_mem       = r_mem;
        n_d1        = r_d1;
        commit      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_mode   = i_mode;
                    n_value  = i_value;
                    n_status = acc_status;
                    n_mem    = acc_mem;
                    n_state  = acc_mem ? S_RD2 : S_DONE;
                end
            end
            S_RD2: begin
                n_d1    = rd_node;
                n_state = S_W1;
            end
            S_W1: begin
                n_state = S_W2;
            end
            S_W2: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    commit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // take the node at the free head
        if (commit && r_status == clm_pkg::ST_OK && take_op) begin
            n_free  = take_fresh ? PW'(r_fresh + 1'b1) : r_d1.nxt;
            n_fresh = take_fresh ? PW'(r_fresh + 1'b1) : r_fresh;
            n_count = r_count + 1'b1;
        end

        if (commit && r_status == clm_pkg::ST_OK) begin
            case (r_mode)
                clm_pkg::MODE_CLEAR: begin
                    if (!empty) n_free = r_head;
                    n_head      = NIL;
                    n_tail      = NIL;
                    n_count     = '0;
                    n_cur       = NIL;
                    n_cidx      = IDX_NONE;
                    n_front_val = '0;
                    n_back_val  = '0;
                    n_cur_val   = '0;
                end
                clm_pkg::MODE_MOVE_FRONT: begin
                    if (!empty) begin
                        n_cur     = r_head;
                        n_cidx    = '0;
                        n_cur_val = r_front_val;
                    end
                end
                clm_pkg::MODE_MOVE_BACK: begin
                    if (!empty) begin
                        n_cur     = r_tail;
                        n_cidx    = $signed({1'b0, cnt_m1[CW-2:0]});
                        n_cur_val = r_back_val;
                    end
                end
                clm_pkg::MODE_MOVE_PREV: begin
                    if (!nocur) begin
                        n_cur     = anc.prv;
                        n_cidx    = (anc.prv == NIL) ? IDX_NONE : r_cidx - 1'b1;
                        n_cur_val = (anc.prv == NIL) ? '0 : rd_node.value;
                    end
                end
                clm_pkg::MODE_MOVE_NEXT: begin
                    if (!nocur) begin
                        n_cur     = anc.nxt;
                        n_cidx    = (anc.nxt == NIL) ? IDX_NONE : r_cidx + 1'b1;
                        n_cur_val = (anc.nxt == NIL) ? '0 : rd_node.value;
                    end
                end
                clm_pkg::MODE_PREPEND: begin
                    n_head      = r_free;
                    n_front_val = r_value;
                    if (empty) begin
                        n_tail     = r_free;
                        n_back_val = r_value;
                    end
                    if (!nocur) n_cidx = r_cidx + 1'b1;
                end
                clm_pkg::MODE_APPEND: begin
                    n_tail     = r_free;
                    n_back_val = r_value;
                    if (empty) begin
                        n_head      = r_free;
                        n_front_val = r_value;
                    end
                end
                clm_pkg::MODE_INS_BEFORE: begin
                    if (anc.prv == NIL) begin
                        n_head      = r_free;
                        n_front_val = r_value;
                    end
                    n_cidx = r_cidx + 1'b1;
                end
                clm_pkg::MODE_INS_AFTER: begin
                    if (anc.nxt == NIL) begin
                        n_tail     = r_free;
                        n_back_val = r_value;
                    end
                end
                clm_pkg::MODE_DEL_FRONT: begin
                    if (r_cur == r_head) begin
                        n_cur     = NIL;
                        n_cidx    = IDX_NONE;
                        n_cur_val = '0;
                    end else if (!nocur) begin
                        n_cidx = r_cidx - 1'b1;
                    end
                    n_head = anc.nxt;
                    if (anc.nxt == NIL) begin
                        n_tail      = NIL;
                        n_front_val = '0;
                        n_back_val  = '0;
                    end else begin
                        n_front_val = rd_node.value;
                    end
                    n_free  = r_head;
                    n_count = r_count - 1'b1;
                end
                clm_pkg::MODE_DEL_BACK: begin
                    if (r_cur == r_tail) begin
                        n_cur     = NIL;
                        n_cidx    = IDX_NONE;
                        n_cur_val = '0;
                    end
                    n_tail = anc.prv;
                    if (anc.prv == NIL) begin
                        n_head      = NIL;
                        n_front_val = '0;
                        n_back_val  = '0;
                    end else begin
                        n_back_val = rd_node.value;
                    end
                    n_free  = r_tail;
                    n_count = r_count - 1'b1;
                end
                clm_pkg::MODE_DEL_CURSOR: begin
                    if (anc.prv == NIL) begin
                        n_head      = anc.nxt;
                        n_front_val = (anc.nxt == NIL) ? '0 : rd_node.value;
                    end
                    if (anc.nxt == NIL) begin
                        n_tail     = anc.prv;
                        n_back_val = (anc.prv == NIL) ? '0 : rd_node.value;
                    end
                    n_cur     = NIL;
                    n_cidx    = IDX_NONE;
                    n_cur_val = '0;
                    n_free    = r_cur;
                    n_count   = r_count - 1'b1;
                end
                default: begin
                    n_cur = r_cur;
                end
            endcase
        end
    end

    // load the result register on commit, drop it when taken
    always_comb begin
        n_out_valid = r_out_valid;
        n_o_status  = r_o_status;
        n_o_len     = r_o_len;
        n_o_cidx    = r_o_cidx;
        n_o_front   = r_o_front;
        n_o_back    = r_o_back;
        n_o_cur     = r_o_cur;
        if (commit) begin
            n_out_valid = 1'b1;
            n_o_status  = r_status;
            n_o_len     = n_count;
            n_o_cidx    = n_cidx;
            n_o_front   = n_front_val;
            n_o_back    = n_back_val;
            n_o_cur     = n_cur_val;
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end
    end

    // hold state, list registers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= NIL;
            r_tail      <= NIL;
            r_cur       <= NIL;
            r_cidx      <= IDX_NONE;
            r_free      <= '0;
            r_fresh     <= '0;
            r_count     <= '0;
            r_front_val <= '0;
            r_back_val  <= '0;
            r_cur_val   <= '0;
            r_mem       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_cur       <= n_cur;
            r_cidx      <= n_cidx;
            r_free      <= n_free;
            r_fresh     <= n_fresh;
            r_count     <= n_count;
            r_front_val <= n_front_val;
            r_back_val  <= n_back_val;
            r_cur_val   <= n_cur_val;
            r_mem       <= n_mem;
            r_out_valid <= n_out_valid;
        end
        r_mode     <= n_mode;
        r_value    <= n_value;
        r_status   <= n_status;
        r_d1       <= n_d1;
        r_o_status <= n_o_status;
        r_o_len    <= n_o_len;
        r_o_cidx   <= n_o_cidx;
        r_o_front  <= n_o_front;
        r_o_back   <= n_o_back;
        r_o_cur    <= n_o_cur;
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_o_status;
    assign o_list_length     = r_o_len;
    assign o_cursor_position = r_o_cidx;
    assign o_front_value     = r_o_front;
    assign o_back_value      = r_o_back;
    assign o_cursor_value    = r_o_cur;

    // the length counter and the head pointer agree on emptiness
    a_len_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == (r_head == NIL))
        else $error("length and head pointer disagree");

    // a defined cursor has a non-negative index and no other
    a_cur_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur == NIL) == r_cidx[CW-1])
        else $error("cursor pointer and index disagree");

    // the cursor index stays inside the list
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cidx[CW-1] |-> (LW'(r_cidx[CW-2:0]) < r_count))
        else $error("cursor index beyond list length");

    // the free head is a recycled node or the first untouched one
    a_free_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free == NIL) || (r_free <= r_fresh))
        else $error("free head above fill mark");

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for cursor_linked_list_manager_unit.
// ----------------------------------------------------------------------------
// Every command that the block accepts is replayed on a queue-based copy of
// the list and its cursor. That copy gives the result the command should
// return. Each result is checked field by field against the oldest waiting
// prediction. The stimulus has four parts. A directed part covers the empty
// list, the undefined cursor and the cursor falling off either end. A random
// mixed part follows. A fill part drives the pool to capacity and probes the
// full-pool refusals. A closing random part runs with no idling. Both sides
// insert random idle bursts everywhere except in the closing part.
`default_nettype none

module testbench;

    localparam int CAP        = 256;
    localparam int IDLE_LIMIT = 2000;
    localparam clm_pkg::t_mode MODE_LAST_CODE = 4'hF;

    typedef struct packed {
        clm_pkg::t_status status;
        logic [8:0]       length;
        logic [8:0]       cur_pos;
        logic [31:0]      front;
        logic [31:0]      back;
        logic [31:0]      cur_val;
    } t_list_result;

    // list copy, cursor copy and the queue of results still owed by the block
    class list_scoreboard;
        logic [31:0]  values[$];
        int           cur_idx;
        t_list_result awaited_results[$];
        int           errors;
        int           checked;

        function new();
            cur_idx = -1;
            errors  = 0;
            checked = 0;
        endfunction

        function int outstanding();
            return awaited_results.size();
        endfunction

        function int list_size();
            return values.size();
        endfunction

        function int cursor();
            return cur_idx;
        endfunction

        function void report(string msg);
            $display("MISMATCH [result %0d]: %s", checked, msg);
            errors++;
        endfunction

        // apply one accepted command and queue the result it should produce
        function void note_command(clm_pkg::t_mode mode, logic [31:0] value);
            t_list_result     r;
            clm_pkg::t_status st;
            int               n;
            st = clm_pkg::ST_OK;
            n  = values.size();
            case (mode)
                clm_pkg::MODE_CLEAR: begin
                    values.delete();
                    cur_idx = -1;
                end
                clm_pkg::MODE_MOVE_FRONT: if (n != 0) cur_idx = 0;
                clm_pkg::MODE_MOVE_BACK:  if (n != 0) cur_idx = n - 1;
                // stepping off the front leaves the index at -1 by itself
                clm_pkg::MODE_MOVE_PREV:  if (cur_idx >= 0) cur_idx--;
                clm_pkg::MODE_MOVE_NEXT: begin
                    if (cur_idx >= 0) begin
                        cur_idx++;
                        if (cur_idx == n) cur_idx = -1;
                    end
                end
                clm_pkg::MODE_PREPEND: begin
                    if (n == CAP) st = clm_pkg::ST_FULL;
                    else begin
                        values.push_front(value);
                        if (cur_idx >= 0) cur_idx++;
                    end
                end
                clm_pkg::MODE_APPEND: begin
                    if (n == CAP) st = clm_pkg::ST_FULL;
                    else values.push_back(value);
                end
                clm_pkg::MODE_INS_BEFORE: begin
                    if (n == 0) st = clm_pkg::ST_EMPTY;
                    else if (cur_idx < 0) st = clm_pkg::ST_NOCUR;
                    else if (n == CAP) st = clm_pkg::ST_FULL;
                    else begin
                        values.insert(cur_idx, value);
                        cur_idx++;
                    end
                end
                clm_pkg::MODE_INS_AFTER: begin
                    if (n == 0) st = clm_pkg::ST_EMPTY;
                    else if (cur_idx < 0) st = clm_pkg::ST_NOCUR;
                    else if (n == CAP) st = clm_pkg::ST_FULL;
                    else values.insert(cur_idx + 1, value);
                end
                clm_pkg::MODE_DEL_FRONT: begin
                    if (n == 0) st = clm_pkg::ST_EMPTY;
                    else begin
                        if (cur_idx == 0) cur_idx = -1;
                        else if (cur_idx > 0) cur_idx--;
                        void'(values.pop_front());
                    end
                end
                clm_pkg::MODE_DEL_BACK: begin
                    if (n == 0) st = clm_pkg::ST_EMPTY;
                    else begin
                        if (cur_idx == n - 1) cur_idx = -1;
                        void'(values.pop_back());
                    end
                end
                clm_pkg::MODE_DEL_CURSOR: begin
                    if (n == 0) st = clm_pkg::ST_EMPTY;
                    else if (cur_idx < 0) st = clm_pkg::ST_NOCUR;
                    else begin
                        values.delete(cur_idx);
                        cur_idx = -1;
                    end
                end
                default: ;
            endcase

            // report the list as it stands after the command
            r.status  = st;
            r.length  = 9'(values.size());
            r.cur_pos = 9'(cur_idx);
            r.front   = (values.size() != 0) ? values[0] : 32'd0;
            r.back    = (values.size() != 0) ? values[values.size() - 1] : 32'd0;
            r.cur_val = (cur_idx >= 0) ? values[cur_idx] : 32'd0;
            awaited_results.push_back(r);
        endfunction

        function void compare_field(string field, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got %h, expected %h", field, got, want));
        endfunction

        function void check_result(t_list_result got);
            t_list_result want;
            checked++;
            if (awaited_results.size() == 0) begin
                report("result arrived with no command outstanding");
            end else begin
                want = awaited_results.pop_front();
                compare_field("status", 32'(got.status), 32'(want.status));
                compare_field("list_length", 32'(got.length), 32'(want.length));
                compare_field("cursor_position", 32'(got.cur_pos), 32'(want.cur_pos));
                compare_field("front_value", got.front, want.front);
                compare_field("back_value", got.back, want.back);
                compare_field("cursor_value", got.cur_val, want.cur_val);
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [3:0]         i_mode;
    logic signed [31:0] i_value;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [1:0]         o_status;
    logic [8:0]         o_list_length;
    logic signed [8:0]  o_cursor_position;
    logic signed [31:0] o_front_value;
    logic signed [31:0] o_back_value;
    logic signed [31:0] o_cursor_value;

    list_scoreboard board = new();
    bit             calm = 1'b0;
    int             stall_left = 0;
    int             idle_cycles = 0;
    t_list_result   seen;

    cursor_linked_list_manager_unit #(.CAPACITY(CAP)) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_mode            (i_mode),
        .i_value           (i_value),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_list_length     (o_list_length),
        .o_cursor_position (o_cursor_position),
        .o_front_value     (o_front_value),
        .o_back_value      (o_back_value),
        .o_cursor_value    (o_cursor_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // check results, generate receiver stall bursts, watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            seen.status  = o_status;
            seen.length  = o_list_length;
            seen.cur_pos = o_cursor_position;
            seen.front   = o_front_value;
            seen.back    = o_back_value;
            seen.cur_val = o_cursor_value;
            board.check_result(seen);
        end

        // drop any leftover burst once the closing part starts
        if (calm) stall_left = 0;
        if (stall_left == 0 && !calm && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 15);
        if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end

        if ((i_in_valid && !o_in_stall) || (o_out_valid === 1'b1 && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // offer one command, with an occasional idle burst ahead of it
    task automatic send_cmd(input clm_pkg::t_mode mode, input logic [31:0] value);
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_value    <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_command(mode, value);
    endtask

    // hold off the sender until every result has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    // weighted command mix for the random parts
    function automatic clm_pkg::t_mode pick_mode();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return clm_pkg::MODE_CLEAR;
        else if (roll < 20)
            return clm_pkg::t_mode'($urandom_range(clm_pkg::MODE_MOVE_FRONT,
                                                   clm_pkg::MODE_MOVE_NEXT));
        else if (roll < 48)
            return clm_pkg::t_mode'($urandom_range(clm_pkg::MODE_PREPEND,
                                                   clm_pkg::MODE_APPEND));
        else if (roll < 66)
            return clm_pkg::t_mode'($urandom_range(clm_pkg::MODE_INS_BEFORE,
                                                   clm_pkg::MODE_INS_AFTER));
        else if (roll < 86)
            return clm_pkg::t_mode'($urandom_range(clm_pkg::MODE_DEL_FRONT,
                                                   clm_pkg::MODE_DEL_CURSOR));
        else if (roll < 94)
            return clm_pkg::MODE_QUERY;
        else
            return clm_pkg::t_mode'($urandom_range(clm_pkg::MODE_QUERY + 1,
                                                   MODE_LAST_CODE));
    endfunction

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_mode      <= clm_pkg::MODE_QUERY;
        i_value     <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list: refusals and no-op moves
        send_cmd(clm_pkg::MODE_QUERY, 32'h0);
        send_cmd(clm_pkg::MODE_MOVE_FRONT, 32'h0);
        send_cmd(clm_pkg::MODE_MOVE_NEXT, 32'h0);
        send_cmd(clm_pkg::MODE_INS_BEFORE, 32'h1234_5678);
        send_cmd(clm_pkg::MODE_DEL_CURSOR, 32'h0);
        send_cmd(clm_pkg::MODE_DEL_FRONT, 32'h0);
        send_cmd(clm_pkg::MODE_DEL_BACK, 32'h0);
        // extreme values, then cursor-relative commands without a cursor
        send_cmd(clm_pkg::MODE_PREPEND, 32'h8000_0000);
        send_cmd(clm_pkg::MODE_APPEND, 32'h7FFF_FFFF);
        send_cmd(clm_pkg::MODE_INS_AFTER, 32'hDEAD_BEEF);
        send_cmd(clm_pkg::MODE_DEL_CURSOR, 32'h0);
        // cursor walks, including stepping off both ends
        send_cmd(clm_pkg::MODE_MOVE_FRONT, 32'h0);
        send_cmd(clm_pkg::MODE_INS_BEFORE, 32'h0000_0000);
        send_cmd(clm_pkg::MODE_INS_AFTER, 32'hFFFF_FFFF);
        send_cmd(clm_pkg::MODE_MOVE_PREV, 32'h0);
        send_cmd(clm_pkg::MODE_MOVE_PREV, 32'h0);
        send_cmd(clm_pkg::MODE_MOVE_BACK, 32'h0);
        send_cmd(clm_pkg::MODE_MOVE_NEXT, 32'h0);
        // delete under the cursor at each end
        send_cmd(clm_pkg::MODE_MOVE_BACK, 32'h0);
        send_cmd(clm_pkg::MODE_DEL_BACK, 32'h0);
        send_cmd(clm_pkg::MODE_MOVE_FRONT, 32'h0);
        send_cmd(clm_pkg::MODE_DEL_FRONT, 32'h0);
        send_cmd(MODE_LAST_CODE, 32'h5A5A_A5A5);
        send_cmd(clm_pkg::MODE_MOVE_FRONT, 32'h0);
        send_cmd(clm_pkg::MODE_DEL_CURSOR, 32'h0);
        send_cmd(clm_pkg::MODE_CLEAR, 32'h0);

        // random mix on a short list
        repeat (150) send_cmd(pick_mode(), $urandom());
        drain();

        // grow the list to capacity with random content
        send_cmd(clm_pkg::MODE_CLEAR, 32'h0);
        send_cmd(clm_pkg::MODE_APPEND, $urandom());
        while (board.list_size() < CAP) begin
            if (board.cursor() < 0)
                send_cmd(clm_pkg::t_mode'($urandom_range(clm_pkg::MODE_MOVE_FRONT,
                                                         clm_pkg::MODE_MOVE_BACK)),
                         $urandom());
            else if ($urandom_range(0, 9) == 0)
                send_cmd(clm_pkg::t_mode'($urandom_range(clm_pkg::MODE_MOVE_PREV,
                                                         clm_pkg::MODE_MOVE_NEXT)),
                         $urandom());
            else
                send_cmd(clm_pkg::t_mode'($urandom_range(clm_pkg::MODE_PREPEND,
                                                         clm_pkg::MODE_INS_AFTER)),
                         $urandom());
        end

        // full pool: every insert is refused, a freed node is reused
        send_cmd(clm_pkg::MODE_MOVE_BACK, 32'h0);
        send_cmd(clm_pkg::MODE_PREPEND, $urandom());
        send_cmd(clm_pkg::MODE_APPEND, $urandom());
        send_cmd(clm_pkg::MODE_INS_BEFORE, $urandom());
        send_cmd(clm_pkg::MODE_INS_AFTER, $urandom());
        send_cmd(clm_pkg::MODE_MOVE_PREV, 32'h0);
        send_cmd(clm_pkg::MODE_DEL_CURSOR, 32'h0);
        send_cmd(clm_pkg::MODE_APPEND, $urandom());
        send_cmd(clm_pkg::MODE_APPEND, $urandom());
        send_cmd(clm_pkg::MODE_DEL_FRONT, 32'h0);
        send_cmd(clm_pkg::MODE_DEL_BACK, 32'h0);

        // closing random part with no idling on either side
        calm = 1'b1;
        repeat (100) send_cmd(pick_mode(), $urandom());

        drain();
        repeat (8) @(posedge i_clk);
        if (board.outstanding() != 0)
            board.report($sformatf("%0d results never arrived", board.outstanding()));
        if (board.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
